[src/double_ended_queue_defines.svh]
// Assertion macros for the double-ended queue.
// Both sample on clk_i; the first is masked while rst_ni is low.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

`define DQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Holds during reset as well.
`define DQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/dq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Shared constants, types and ring helpers for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH   = 16;
  localparam int DATA_W  = 32;
  localparam int VALUE_W = 32;
  localparam int CMD_W   = 3;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 2;
  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SUM_W   = PTR_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_QUERY      = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_PUSH_FRONT = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_PUSH_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD
  } state_e;

  // Controller to datapath strobes.
  typedef struct packed {
    logic take;   // apply the accepted command
    logic read;   // fetch front and back entries
    logic load;   // move the result into the output register
  } dq_ctrl_t;

  // (base + offset) modulo DEPTH; base < DEPTH, offset <= DEPTH.
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] offset);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(offset);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return PTR_W'(s);
  endfunction

  function automatic logic [DATA_W-1:0] to_store(input logic signed [VALUE_W-1:0] v);
    return DATA_W'(v);
  endfunction

  function automatic logic [VALUE_W-1:0] to_output(input logic [DATA_W-1:0] v);
    logic signed [DATA_W-1:0] s;
    s = v;
    return VALUE_W'(s);
  endfunction

endpackage

[src/dq_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_in_if / dq_out_if
// Valid/ready channels carrying queue commands and queue results.
// ----------------------------------------------------------------------------
interface dq_in_if import dq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface dq_out_if import dq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] front_value;
  logic signed [VALUE_W-1:0] back_value;
  logic [COUNT_W-1:0]        count;
  logic                      is_empty;
  logic [STAT_W-1:0]         status;

  modport source (output valid, front_value, back_value, count, is_empty, status,
                  input ready);
  modport sink   (input valid, front_value, back_value, count, is_empty, status,
                  output ready);
endinterface

[src/double_ended_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed values held in a ring, with a per-command report.
// ----------------------------------------------------------------------------
// Usage notes
//  - in_i carries one command (query, push back, push front, pop front,
//    pop back) and a value; a transaction completes when valid and ready
//    are both high. Unused command codes act as a query.
//  - out_o returns exactly one result per input transaction: front and back
//    entries (all ones when empty), entry count, empty flag and status
//    (ok, pop on empty refused, push on full refused).
//  - The result is registered through update and write, ring read and
//    output register load, in that order.
//  - A new transaction is taken only once the previous one has been through
//    the sequence take / read / load around the single-write, two-read ring.
//  - The output register decouples the sides: a new command is taken while
//    an earlier result waits. If the receiver stalls, the next result is
//    held in the read stage until the output register empties.
//  - Reset (rst_ni low, asynchronous) empties the queue: head and count
//    clear at once; ring contents are left as they are and never reported
//    before being written. No clearing pass is needed.
// ----------------------------------------------------------------------------
`include "double_ended_queue_defines.svh"

module double_ended_queue import dq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  dq_in_if.sink   in_i,
  dq_out_if.source out_o
);

  dq_ctrl_t ctrl;

  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .ctrl_o      (ctrl)
  );

  dq_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .command_i     (in_i.command),
    .value_i       (in_i.value),
    .front_value_o (out_o.front_value),
    .back_value_o  (out_o.back_value),
    .count_o       (out_o.count),
    .is_empty_o    (out_o.is_empty),
    .status_o      (out_o.status)
  );

  // Sequencing: a taken transaction is always followed by the ring read.
  `DQ_ASSERT(a_take_then_read, ctrl.take |=> ctrl.read, "ring read did not follow take")

  // No new transaction is taken while a read or load is in flight.
  `DQ_ASSERT_ALWAYS(a_ready_exclusive, in_i.ready |-> !ctrl.read && !ctrl.load,
                    "input ready while a transaction is in flight")

  // Reported count never exceeds the ring size and agrees with the empty flag.
  `DQ_ASSERT(a_count_consistent,
             out_o.valid |-> (out_o.count <= COUNT_W'(DEPTH)) &&
                             (out_o.is_empty == (out_o.count == '0)),
             "reported count inconsistent")

  // An empty queue reports all ones at both ends.
  `DQ_ASSERT(a_empty_ends,
             out_o.valid && out_o.is_empty |->
               (out_o.front_value == '1) && (out_o.back_value == '1),
             "empty queue end values not all ones")

endmodule

[src/dq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer: take a transaction, read the ring, load the output register.
// ----------------------------------------------------------------------------
module dq_ctrl import dq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dq_ctrl_t ctrl_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    ctrl_o     = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.take = 1'b1;
          state_d     = S_READ;
        end
      end
      S_READ: begin
        ctrl_o.read = 1'b1;
        state_d     = S_LOAD;
      end
      S_LOAD: begin
        // wait for the output register to drain
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.load = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = out_valid_q;
    if (ctrl_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[src/dq_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_datapath
// Ring store, head pointer, entry count and output register.
// ----------------------------------------------------------------------------
module dq_datapath import dq_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dq_ctrl_t                  ctrl_i,
  input  logic [CMD_W-1:0]          command_i,
  input  logic signed [VALUE_W-1:0] value_i,
  output logic signed [VALUE_W-1:0] front_value_o,
  output logic signed [VALUE_W-1:0] back_value_o,
  output logic [COUNT_W-1:0]        count_o,
  output logic                      is_empty_o,
  output logic [STAT_W-1:0]         status_o
);

  logic [PTR_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  status_e           status_q, status_d;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_front_q, rd_back_q;

  logic [VALUE_W-1:0] front_q, back_q;
  logic [COUNT_W-1:0] count_out_q;
  logic               empty_q;
  logic [STAT_W-1:0]  status_out_q;

  logic [PTR_W-1:0] tail_addr, back_addr, head_dec, head_inc, wr_addr;
  logic             full, empty, wr_en;
  cmd_e             cmd;

  assign full      = (count_q == CNT_W'(DEPTH));
  assign empty     = (count_q == '0);
  assign tail_addr = ring_add(head_q, count_q);
  assign back_addr = empty ? head_q : ring_add(head_q, count_q - CNT_W'(1));
  assign head_inc  = ring_add(head_q, CNT_W'(1));
  assign head_dec  = (head_q == '0) ? PTR_W'(DEPTH - 1) : head_q - PTR_W'(1);
  assign cmd       = cmd_e'(command_i);

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    status_d = ST_OK;
    wr_en    = 1'b0;
    wr_addr  = tail_addr;
    unique case (cmd)
      CMD_PUSH_BACK: begin
        if (full) begin
          status_d = ST_PUSH_FULL;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      CMD_PUSH_FRONT: begin
        if (full) begin
          status_d = ST_PUSH_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_addr = head_dec;
          head_d  = head_dec;
          count_d = count_q + CNT_W'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status_d = ST_POP_EMPTY;
        end else begin
          head_d  = head_inc;
          count_d = count_q - CNT_W'(1);
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          status_d = ST_POP_EMPTY;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
      default: ;  // query and unused codes
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      status_q <= ST_OK;
    end else if (ctrl_i.take) begin
      head_q   <= head_d;
      count_q  <= count_d;
      status_q <= status_d;
    end
  end

  // Ring store: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.take && wr_en) begin
      mem_q[wr_addr] <= to_store(value_i);
    end
    if (ctrl_i.read) begin
      rd_front_q <= mem_q[head_q];
      rd_back_q  <= mem_q[back_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      front_q      <= empty ? '1 : to_output(rd_front_q);
      back_q       <= empty ? '1 : to_output(rd_back_q);
      count_out_q  <= COUNT_W'(count_q);
      empty_q      <= empty;
      status_out_q <= status_q;
    end
  end

  assign front_value_o = front_q;
  assign back_value_o  = back_q;
  assign count_o       = count_out_q;
  assign is_empty_o    = empty_q;
  assign status_o      = status_out_q;

endmodule

[bench/double_ended_queue_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking bench for the bounded deque. Commands are driven on the input
// channel while a ring model in a small scoreboard works out front, back,
// count, empty flag and status for every transaction. Each result taken from
// the output channel is compared field by field with the oldest prediction.
// Stimulus is a short directed run followed by random fill, drain and mixed
// bursts, with random idling on both sides, a long receiver hold-off and a
// sender pause until the queue of predictions has drained.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
  import dq_pkg::*;

  localparam int RANDOM_ITEMS = 1600;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int TAIL_CYCLES  = 8;     // settling margin after the drain
  localparam int IDLE_PCT     = 7;

  // Codes 5 to 7 are unused and must behave as a query
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;

  typedef enum int {
    BURST_FILL,
    BURST_DRAIN,
    BURST_MIXED
  } burst_e;

  typedef struct packed {
    logic signed [VALUE_W-1:0] front_value;
    logic signed [VALUE_W-1:0] back_value;
    logic [COUNT_W-1:0]        count;
    logic                      is_empty;
    logic [STAT_W-1:0]         status;
  } dq_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: ring model of the deque plus the queue of predicted results
  // --------------------------------------------------------------------------
  class deque_scoreboard;
    logic [DATA_W-1:0] ring [DEPTH];
    int unsigned       head;
    int unsigned       held;
    dq_result_t        predicted_q[$];
    int unsigned       mismatches;
    int unsigned       transactions;
    int unsigned       results_checked;
    int unsigned       empty_refusals;
    int unsigned       full_refusals;
    int unsigned       peak;

    function new();
      head            = 0;
      held            = 0;
      mismatches      = 0;
      transactions    = 0;
      results_checked = 0;
      empty_refusals  = 0;
      full_refusals   = 0;
      peak            = 0;
    endfunction

    function int unsigned pending();
      return predicted_q.size();
    endfunction

    // Applies one accepted command to the model and queues the report
    function void note_command(logic [CMD_W-1:0] cmd, logic signed [VALUE_W-1:0] val);
      dq_result_t r;
      r.status = ST_OK;
      case (cmd)
        CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
          if (held == DEPTH) begin
            r.status = ST_PUSH_FULL;
            full_refusals++;
          end else if (cmd == CMD_PUSH_BACK) begin
            ring[(head + held) % DEPTH] = DATA_W'(val);
            held++;
          end else begin
            head       = (head + DEPTH - 1) % DEPTH;
            ring[head] = DATA_W'(val);
            held++;
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          if (held == 0) begin
            r.status = ST_POP_EMPTY;
            empty_refusals++;
          end else begin
            if (cmd == CMD_POP_FRONT) begin
              head = (head + 1) % DEPTH;
            end
            held--;
          end
        end
        default: begin
          // query and unused codes leave the ring alone
        end
      endcase
      if (held == 0) begin
        r.front_value = '1;
        r.back_value  = '1;
      end else begin
        r.front_value = VALUE_W'($signed(ring[head]));
        r.back_value  = VALUE_W'($signed(ring[(head + held - 1) % DEPTH]));
      end
      r.count    = COUNT_W'(held);
      r.is_empty = (held == 0);
      if (held > peak) begin
        peak = held;
      end
      transactions++;
      predicted_q = {predicted_q, r};
    endfunction

    function void compare_field(string field, longint want_v, longint got_v);
      if (want_v != got_v) begin
        $error("%s: expected %0d, got %0d", field, want_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_result(dq_result_t got);
      dq_result_t want;
      if (predicted_q.size() == 0) begin
        $error("result with nothing predicted: front %0d back %0d count %0d status %0d",
               got.front_value, got.back_value, got.count, got.status);
        mismatches++;
        return;
      end
      want = predicted_q[0];
      predicted_q.delete(0);
      results_checked++;
      compare_field("front_value", want.front_value, got.front_value);
      compare_field("back_value",  want.back_value,  got.back_value);
      compare_field("count",       want.count,       got.count);
      compare_field("is_empty",    want.is_empty,    got.is_empty);
      compare_field("status",      want.status,      got.status);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #4 clk_i = ~clk_i;

  dq_in_if  in_if ();
  dq_out_if out_if ();

  double_ended_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  deque_scoreboard sb = new();

  // Shared between the sender and the receiver
  bit quiet        = 1'b0;  // no idling on either side
  bit hold_request = 1'b0;  // asks the receiver for a long hold-off

  // --------------------------------------------------------------------------
  // Sender helpers
  // --------------------------------------------------------------------------
  // Offers one transaction. Random idle cycles go in front of it; valid stays
  // high across back-to-back transactions. Acceptance is decided at the
  // falling edge, where valid and ready are both settled.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic signed [VALUE_W-1:0] val);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.command <= cmd;
    in_if.value   <= val;
    do @(negedge clk_i); while (!in_if.ready);
    sb.note_command(cmd, val);
    @(posedge clk_i);
  endtask

  // Drops valid and waits until every predicted result has come back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0:       return {1'b0, {(VALUE_W-1){1'b1}}};
      1:       return {1'b1, {(VALUE_W-1){1'b0}}};
      2:       return VALUE_W'(int'($urandom_range(0, 31)) - 16);
      default: return $urandom;
    endcase
  endfunction

  // Fill bursts push the ring against full, drain bursts against empty
  function automatic logic [CMD_W-1:0] pick_command(burst_e mode);
    int roll;
    int push_pct;
    int pop_pct;
    roll = $urandom_range(0, 99);
    case (mode)
      BURST_FILL:  begin push_pct = 70; pop_pct = 20; end
      BURST_DRAIN: begin push_pct = 20; pop_pct = 70; end
      default:     begin push_pct = 42; pop_pct = 45; end
    endcase
    if (roll < push_pct) begin
      return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    end
    if (roll < push_pct + pop_pct) begin
      return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
    end
    if (roll < push_pct + pop_pct + 5) begin
      return CMD_UNUSED_LO + CMD_W'($urandom_range(0, 2));
    end
    return CMD_QUERY;
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure, long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left    = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
      end else begin
        out_if.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Result monitor: a transaction is taken at the next rising edge
  initial begin
    dq_result_t got;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        got.front_value = out_if.front_value;
        got.back_value  = out_if.back_value;
        got.count       = out_if.count;
        got.is_empty    = out_if.is_empty;
        got.status      = out_if.status;
        sb.check_result(got);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int     sent;
    int     burst_len;
    burst_e mode;
    bit     held_off;
    bit     paused;
    sent     = 0;
    held_off = 1'b0;
    paused   = 1'b0;

    in_if.valid   <= 1'b0;
    in_if.command <= CMD_QUERY;
    in_if.value   <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty queue first - query, both pops refused, unused codes
    send_item(CMD_QUERY,      32'sd0);
    send_item(CMD_POP_FRONT,  32'sd0);
    send_item(CMD_POP_BACK,   -32'sd1);
    send_item(CMD_UNUSED_LO,      32'sd5);
    send_item(CMD_UNUSED_LO + 3'd1, -32'sd7);
    send_item(CMD_UNUSED_LO + 3'd2, 32'sd0);
    // extremes at both ends, -1 held as a real entry
    send_item(CMD_PUSH_BACK,  32'sh7fffffff);
    send_item(CMD_PUSH_FRONT, 32'sh80000000);
    send_item(CMD_PUSH_BACK,  -32'sd1);
    send_item(CMD_PUSH_FRONT, 32'sd0);
    send_item(CMD_QUERY,      32'sh7fffffff);
    send_item(CMD_UNUSED_LO + 3'd2, 32'sh55555555);
    send_item(CMD_POP_FRONT,  32'sd0);
    send_item(CMD_POP_BACK,   32'sd0);
    send_item(CMD_POP_BACK,   32'sd0);
    send_item(CMD_POP_FRONT,  32'sd0);
    // back to empty: a refused pop, one entry seen from both ends, then another refused pop
    send_item(CMD_POP_BACK,   32'sd0);
    send_item(CMD_PUSH_FRONT, 32'shaaaaaaaa);
    send_item(CMD_POP_BACK,   32'sd0);
    send_item(CMD_POP_FRONT,  32'sd0);

    // Random bursts
    while (sent < RANDOM_ITEMS) begin
      mode      = burst_e'($urandom_range(0, 2));
      burst_len = $urandom_range(8, 48);
      // Long receiver hold-off while the sender keeps offering: the
      // pipeline fills and the input stalls
      if (!held_off && sent >= 400) begin
        held_off     = 1'b1;
        hold_request = 1'b1;
      end
      // Sender pause until everything outstanding has come back
      if (!paused && sent >= 900) begin
        paused = 1'b1;
        wait_drained();
      end
      quiet = (sent >= 1100 && sent < 1400);
      repeat (burst_len) begin
        send_item(pick_command(mode), rand_value());
        sent++;
      end
    end
    quiet = 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d transactions, checked %0d results, peak occupancy %0d of %0d.",
             sb.transactions, sb.results_checked, sb.peak, DEPTH);
    $display("Refused pops on empty: %0d, refused pushes on full: %0d.",
             sb.empty_refusals, sb.full_refusals);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
